// ===== hdl/dmg_pkg.sv =====
// Shared types, constants and the neighbour permutation function of the maze generator.
package dmg_pkg;

  localparam int GRID_W  = 7;
  localparam int COORD_W = 6;
  localparam int PICK_W  = 5;
  localparam int POS_W   = 3;
  localparam int EPOCH_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 2'd2;

  localparam logic [GRID_W-1:0]  GRID_RESET  = 7'd8;
  localparam logic [COORD_W-1:0] START_RESET = 6'd0;

  typedef struct packed {
    logic              restart;
    logic [PICK_W-1:0] random_pick;
  } in_item_t;

  typedef struct packed {
    logic               edge_valid;
    logic [COORD_W-1:0] from_x;
    logic [COORD_W-1:0] from_y;
    logic [COORD_W-1:0] to_x;
    logic [COORD_W-1:0] to_y;
    logic               walk_done;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_RESTART,
    ST_SCAN,
    ST_VISIT,
    ST_POP,
    ST_EMIT
  } state_t;

  // Lexicographic permutation number (pick mod k!) of k list slots.
  function automatic logic [3:0][1:0] perm_order(input logic [2:0] k,
                                                 input logic [PICK_W-1:0] pick);
    logic [PICK_W-1:0] i;
    logic [3:0][1:0]   dig;
    logic [3:0][1:0]   lst;
    logic [3:0][1:0]   ord;
    i   = pick;
    dig = '0;
    case (k)
      3'd4: begin
        if (i >= 5'd24) i = i - 5'd24;
        if (i >= 5'd18) begin
          dig[0] = 2'd3;
          i = i - 5'd18;
        end else if (i >= 5'd12) begin
          dig[0] = 2'd2;
          i = i - 5'd12;
        end else if (i >= 5'd6) begin
          dig[0] = 2'd1;
          i = i - 5'd6;
        end
        dig[1] = i[2:1];
        dig[2] = {1'b0, i[0]};
      end
      3'd3: begin
        if (i >= 5'd24) i = i - 5'd24;
        if (i >= 5'd12) i = i - 5'd12;
        if (i >= 5'd6) i = i - 5'd6;
        dig[0] = i[2:1];
        dig[1] = {1'b0, i[0]};
      end
      3'd2: begin
        dig[0] = {1'b0, i[0]};
      end
      default: ;
    endcase
    lst = {2'd3, 2'd2, 2'd1, 2'd0};
    ord = '0;
    for (int n = 0; n < 4; n++) begin
      ord[n] = lst[dig[n]];
      for (int j = 0; j < 3; j++) begin
        if (j >= int'(dig[n])) lst[j] = lst[j+1];
      end
    end
    return ord;
  endfunction

endpackage

// ===== hdl/dfs_maze_generator.sv =====
// Top level of the depth-first maze generator: sequencer, frame stack and visited map.
//
// Input channel in_valid/in_stall/in_item carries one item per maze step; the result
// channel out_valid/out_stall/out_item returns exactly one item for each input item.
// Configuration (grid size, start x, start y) is written through cfg_we/cfg_index/
// cfg_wdata while the block is idle.
// A restart item passes through the restart state, after the epoch sweep when one is due,
// then the emit state; an item answered with walk_done while no walk is active goes
// straight to the emit state. An ordinary item alternates scan and visit states, one
// visited-bit lookup per visit, with a pop state for each stack frame popped; one that
// carves at its first lookup goes scan, visit, emit. The visited map and the frame stack
// are single-port-read RAMs with registered read data. One item is in work at a time.
// The visited map is tagged with a 4-bit walk epoch; every fifteenth restart wraps the
// epoch and first sweeps all GRID_MAX*GRID_MAX map entries (4096 by default).
// After reset the same sweep runs before the first item is taken; in_stall is high
// throughout it. The walk starts with no active maze, answering walk_done.
// The result sits in an output register: a stalled receiver holds it there while the
// block prepares the next result, and a further item waits in in_stall until the
// register frees.
module dfs_maze_generator #(
  parameter int GRID_MAX = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dmg_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dmg_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [dmg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmg_pkg::GRID_W-1:0]          cfg_wdata
);

  localparam int CW    = (GRID_MAX > 2) ? $clog2(GRID_MAX) : 1;
  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int VA    = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS + 1);
  localparam int SZW   = ((dmg_pkg::GRID_W > CW + 1) ? dmg_pkg::GRID_W : CW + 1) + 1;
  localparam int PW    = dmg_pkg::PICK_W;
  localparam int QW    = dmg_pkg::POS_W;
  localparam int EW    = dmg_pkg::EPOCH_W;
  localparam int FW    = 2 * CW + PW + QW;

  dmg_pkg::state_t state_r, state_nxt;

  logic [dmg_pkg::GRID_W-1:0]  grid_r;
  logic [dmg_pkg::COORD_W-1:0] start_x_r, start_y_r;

  logic [EW-1:0]  epoch_r, epoch_nxt;
  logic [VA-1:0]  wipe_cnt_r, wipe_cnt_nxt;
  logic           wipe_rs_r, wipe_rs_nxt;
  logic [DW-1:0]  depth_r, depth_nxt;
  logic           finished_r, finished_nxt;
  logic [CW-1:0]  top_x_r, top_x_nxt, top_y_r, top_y_nxt;
  logic [PW-1:0]  top_pick_r, top_pick_nxt;
  logic [QW-1:0]  top_pos_r, top_pos_nxt;
  logic [CW-1:0]  cand_x_r, cand_x_nxt, cand_y_r, cand_y_nxt;
  logic [PW-1:0]  item_pick_r, item_pick_nxt;
  dmg_pkg::out_item_t res_r, res_nxt, out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic           vis_we;
  logic [VA-1:0]  vis_waddr, vis_raddr;
  logic [EW-1:0]  vis_wdata, vis_rdata;
  logic           stk_we;
  logic [VA-1:0]  stk_waddr, stk_raddr;
  logic [FW-1:0]  stk_wdata, stk_rdata;

  logic [SZW-1:0]  gs_ext, s_eff, tx, ty, sx_ext, sy_ext;
  logic [CW-1:0]   start_cx, start_cy;
  logic [3:0]      nb_ok;
  logic [CW-1:0]   nb_x [4];
  logic [CW-1:0]   nb_y [4];
  logic [3:0][1:0] slot_dir;
  logic [2:0]      nb_cnt;
  logic [3:0][1:0] ord;
  logic [1:0]      sel_dir;
  logic [CW-1:0]   cand_x, cand_y;
  logic            exhausted;

  function automatic logic [VA-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return VA'(int'(x) * GRID_MAX + int'(y));
  endfunction

  dmg_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  dmg_ram #(.WIDTH(FW), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // effective size and start cell
  always_comb begin
    gs_ext = SZW'(grid_r);
    if (gs_ext == '0) s_eff = SZW'(1);
    else if (gs_ext > SZW'(GRID_MAX)) s_eff = SZW'(GRID_MAX);
    else s_eff = gs_ext;
    sx_ext = SZW'(start_x_r);
    sy_ext = SZW'(start_y_r);
    start_cx = CW'((sx_ext < s_eff) ? sx_ext : s_eff - SZW'(1));
    start_cy = CW'((sy_ext < s_eff) ? sy_ext : s_eff - SZW'(1));
  end

  // in-range neighbours of the top frame, in permuted order
  always_comb begin
    tx = SZW'(top_x_r);
    ty = SZW'(top_y_r);
    nb_ok[0] = (tx != '0) && ((tx - SZW'(1)) < s_eff);
    nb_ok[1] = (tx + SZW'(1)) < s_eff;
    nb_ok[2] = (ty != '0) && ((ty - SZW'(1)) < s_eff);
    nb_ok[3] = (ty + SZW'(1)) < s_eff;
    nb_x[0] = top_x_r - CW'(1);
    nb_y[0] = top_y_r;
    nb_x[1] = top_x_r + CW'(1);
    nb_y[1] = top_y_r;
    nb_x[2] = top_x_r;
    nb_y[2] = top_y_r - CW'(1);
    nb_x[3] = top_x_r;
    nb_y[3] = top_y_r + CW'(1);
    slot_dir = '0;
    nb_cnt = '0;
    for (int d = 0; d < 4; d++) begin
      if (nb_ok[d]) begin
        slot_dir[nb_cnt[1:0]] = 2'(d);
        nb_cnt = nb_cnt + 3'd1;
      end
    end
    ord = dmg_pkg::perm_order(nb_cnt, top_pick_r);
    sel_dir = slot_dir[ord[top_pos_r[1:0]]];
    cand_x = nb_x[sel_dir];
    cand_y = nb_y[sel_dir];
    exhausted = top_pos_r >= nb_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r    <= dmg_pkg::GRID_RESET;
      start_x_r <= dmg_pkg::START_RESET;
      start_y_r <= dmg_pkg::START_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dmg_pkg::CFG_GRID_SIZE: grid_r    <= cfg_wdata;
        dmg_pkg::CFG_START_X:   start_x_r <= cfg_wdata[dmg_pkg::COORD_W-1:0];
        dmg_pkg::CFG_START_Y:   start_y_r <= cfg_wdata[dmg_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmg_pkg::ST_WIPE;
      epoch_r     <= EW'(1);
      wipe_cnt_r  <= '0;
      wipe_rs_r   <= 1'b0;
      depth_r     <= '0;
      finished_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      wipe_cnt_r  <= wipe_cnt_nxt;
      wipe_rs_r   <= wipe_rs_nxt;
      depth_r     <= depth_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_x_r     <= top_x_nxt;
    top_y_r     <= top_y_nxt;
    top_pick_r  <= top_pick_nxt;
    top_pos_r   <= top_pos_nxt;
    cand_x_r    <= cand_x_nxt;
    cand_y_r    <= cand_y_nxt;
    item_pick_r <= item_pick_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    wipe_cnt_nxt  = wipe_cnt_r;
    wipe_rs_nxt   = wipe_rs_r;
    depth_nxt     = depth_r;
    finished_nxt  = finished_r;
    top_x_nxt     = top_x_r;
    top_y_nxt     = top_y_r;
    top_pick_nxt  = top_pick_r;
    top_pos_nxt   = top_pos_r;
    cand_x_nxt    = cand_x_r;
    cand_y_nxt    = cand_y_r;
    item_pick_nxt = item_pick_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    vis_we    = 1'b0;
    vis_waddr = cell_addr(cand_x_r, cand_y_r);
    vis_wdata = epoch_r;
    vis_raddr = cell_addr(cand_x, cand_y);
    stk_we    = 1'b0;
    stk_waddr = VA'(depth_r - DW'(1));
    stk_wdata = {top_x_r, top_y_r, top_pick_r, top_pos_r};
    stk_raddr = VA'(depth_r - DW'(2));

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      dmg_pkg::ST_WIPE: begin
        vis_we    = 1'b1;
        vis_waddr = wipe_cnt_r;
        vis_wdata = '0;
        if (wipe_cnt_r == VA'(CELLS - 1)) begin
          wipe_cnt_nxt = '0;
          epoch_nxt    = EW'(1);
          wipe_rs_nxt  = 1'b0;
          state_nxt    = wipe_rs_r ? dmg_pkg::ST_RESTART : dmg_pkg::ST_IDLE;
        end else begin
          wipe_cnt_nxt = wipe_cnt_r + VA'(1);
        end
      end
      dmg_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_pick_nxt = in_item.random_pick;
          res_nxt       = '0;
          if (in_item.restart) begin
            top_x_nxt    = start_cx;
            top_y_nxt    = start_cy;
            top_pick_nxt = in_item.random_pick;
            top_pos_nxt  = '0;
            depth_nxt    = DW'(1);
            finished_nxt = 1'b0;
            if (epoch_r == '1) begin
              wipe_rs_nxt = 1'b1;
              state_nxt   = dmg_pkg::ST_WIPE;
            end else begin
              epoch_nxt = epoch_r + EW'(1);
              state_nxt = dmg_pkg::ST_RESTART;
            end
          end else if (finished_r) begin
            res_nxt.walk_done = 1'b1;
            state_nxt         = dmg_pkg::ST_EMIT;
          end else begin
            state_nxt = dmg_pkg::ST_SCAN;
          end
        end
      end
      dmg_pkg::ST_RESTART: begin
        vis_we    = 1'b1;
        vis_waddr = cell_addr(top_x_r, top_y_r);
        state_nxt = dmg_pkg::ST_EMIT;
      end
      dmg_pkg::ST_SCAN: begin
        if (depth_r == '0) begin
          finished_nxt      = 1'b1;
          res_nxt.walk_done = 1'b1;
          state_nxt         = dmg_pkg::ST_EMIT;
        end else if (exhausted) begin
          depth_nxt = depth_r - DW'(1);
          state_nxt = (depth_r > DW'(1)) ? dmg_pkg::ST_POP : dmg_pkg::ST_SCAN;
        end else begin
          cand_x_nxt  = cand_x;
          cand_y_nxt  = cand_y;
          top_pos_nxt = top_pos_r + QW'(1);
          state_nxt   = dmg_pkg::ST_VISIT;
        end
      end
      dmg_pkg::ST_VISIT: begin
        if (vis_rdata == epoch_r) begin
          state_nxt = dmg_pkg::ST_SCAN;
        end else begin
          vis_we             = 1'b1;
          stk_we             = 1'b1;
          res_nxt.edge_valid = 1'b1;
          res_nxt.from_x     = dmg_pkg::COORD_W'(top_x_r);
          res_nxt.from_y     = dmg_pkg::COORD_W'(top_y_r);
          res_nxt.to_x       = dmg_pkg::COORD_W'(cand_x_r);
          res_nxt.to_y       = dmg_pkg::COORD_W'(cand_y_r);
          top_x_nxt          = cand_x_r;
          top_y_nxt          = cand_y_r;
          top_pick_nxt       = item_pick_r;
          top_pos_nxt        = '0;
          depth_nxt          = depth_r + DW'(1);
          state_nxt          = dmg_pkg::ST_EMIT;
        end
      end
      dmg_pkg::ST_POP: begin
        {top_x_nxt, top_y_nxt, top_pick_nxt, top_pos_nxt} = stk_rdata;
        state_nxt = dmg_pkg::ST_SCAN;
      end
      dmg_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = dmg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dmg_pkg::ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != dmg_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while the previous one is in work");

  a_edge_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.edge_valid |-> !out_r.walk_done)
    else $error("result carries an edge and done together");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(CELLS))
    else $error("frame stack overflow");

  a_visit_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dmg_pkg::ST_VISIT |-> $past(state_r) == dmg_pkg::ST_SCAN)
    else $error("visited check without a lookup issued");

endmodule

// ===== hdl/dmg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dmg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
